// ----- design/pcc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types, codes and constants of the phone call control block.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int MAX_DIGITS_DEF = 16;
  localparam int COUNT_W        = 5;
  localparam int NUMBER_W       = 64;
  localparam int NIBBLES        = NUMBER_W / 4;

  localparam logic [1:0] SERVICE_REPEAT_RST = 2'd3;
  localparam logic [3:0] DIGIT_ZERO         = 4'd0;
  localparam logic [3:0] DIGIT_NINE         = 4'd9;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_TONE     = 3'd1,
    MODE_DIALING  = 3'd2,
    MODE_OUTGOING = 3'd3,
    MODE_RINGING  = 3'd4,
    MODE_INCALL   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    OP_HOOK_OFF = 3'd0,
    OP_HOOK_ON  = 3'd1,
    OP_DIGIT    = 3'd2,
    OP_TIMEOUT  = 3'd3,
    OP_INCOMING = 3'd4,
    OP_ANSWERED = 3'd5,
    OP_CALL_END = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    TONE_NONE = 2'd0,
    TONE_STOP = 2'd1,
    TONE_DIAL = 2'd2,
    TONE_BUSY = 2'd3
  } tone_cmd_t;

  typedef enum logic [1:0] {
    BELL_NONE  = 2'd0,
    BELL_RING  = 2'd1,
    BELL_HALT  = 2'd2,
    BELL_PULSE = 2'd3
  } bell_cmd_t;

  typedef enum logic [1:0] {
    CALL_NONE   = 2'd0,
    CALL_PLACE  = 2'd1,
    CALL_ANSWER = 2'd2,
    CALL_HANGUP = 2'd3
  } call_cmd_t;

  typedef enum logic [1:0] {
    TIMER_NONE    = 2'd0,
    TIMER_RESTART = 2'd1,
    TIMER_STOP    = 2'd2
  } timer_cmd_t;

  // control from the state machine to the digit store
  typedef struct packed {
    logic take;
    logic clear;
  } dig_ctrl_t;

  // digit store status seen by the state machine
  typedef struct packed {
    logic count_is_two;
    logic first_zero;
    logic second_zero;
  } dig_stat_t;

  // commands and mode produced by one event
  typedef struct packed {
    mode_t      mode;
    tone_cmd_t  tone;
    bell_cmd_t  bell;
    call_cmd_t  call;
    timer_cmd_t timer;
    logic       clr;
    logic       test;
  } cmd_t;

endpackage
`default_nettype wire

// ----- design/pcc_digits.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_digits
// Dialed digit store: collects digits in order, clears on dial tone entry.
// ----------------------------------------------------------------------------
module pcc_digits
  import pcc_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire dig_ctrl_t           ctrl,
  input  wire logic [3:0]          digit,
  output dig_stat_t                stat,
  output logic [COUNT_W-1:0]       count_next,
  output logic [NUMBER_W-1:0]      number_next
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [3:0]         store      [MAX_DIGITS];
  logic [3:0]         store_next [MAX_DIGITS];
  logic [COUNT_W-1:0] count;
  logic               has_room;
  logic [IDX_W-1:0]   wr_idx;

  assign has_room = (count < COUNT_W'(MAX_DIGITS));
  assign wr_idx   = count[IDX_W-1:0];

  assign stat.count_is_two = (count == COUNT_W'(2));
  assign stat.first_zero   = (store[0] == DIGIT_ZERO);
  assign stat.second_zero  = (store[1] == DIGIT_ZERO);

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (ctrl.clear) begin
        store_next[i] = DIGIT_ZERO;
      end else if (ctrl.take && has_room && (wr_idx == IDX_W'(i))) begin
        store_next[i] = digit;
      end else begin
        store_next[i] = store[i];
      end
    end
  end

  always_comb begin
    if (ctrl.clear) begin
      count_next = '0;
    end else if (ctrl.take && has_room) begin
      count_next = count + COUNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  // nibbles past the last taken digit always hold zero
  always_comb begin
    number_next = '0;
    for (int i = 0; i < NIBBLES; i++) begin
      if (i < MAX_DIGITS) begin
        number_next[4*i +: 4] = store_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        store[i] <= DIGIT_ZERO;
      end
    end else if (en) begin
      count <= count_next;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        store[i] <= store_next[i];
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/pcc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_ctrl
// Call mode state machine with on-hook service code run counters.
// ----------------------------------------------------------------------------
module pcc_ctrl
  import pcc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire logic [2:0] op_code,
  input  wire logic [3:0] digit,
  input  wire logic       link,
  input  wire logic [1:0] repeat_cnt,
  input  wire dig_stat_t  stat,
  output dig_ctrl_t       dig_ctrl,
  output cmd_t            cmd
);

  mode_t      mode;
  mode_t      mode_next;
  logic [1:0] nines_run;
  logic [1:0] nines_run_next;
  logic [1:0] zeros_run;
  logic [1:0] zeros_run_next;

  op_t        op;
  logic       go;
  logic       pulse;
  logic       restart;
  logic       test;
  logic       clr;
  call_cmd_t  call_x;
  logic       nines_hit;
  logic       zeros_hit;
  logic       three_zeros;

  assign op = op_t'(op_code);

  assign nines_hit = ({1'b0, nines_run} + 3'd1) >= {1'b0, repeat_cnt};
  assign zeros_hit = ({1'b0, zeros_run} + 3'd1) >= {1'b0, repeat_cnt};

  // third stored digit completes 000 with the link down
  assign three_zeros = stat.count_is_two && stat.first_zero && stat.second_zero
                       && (digit == DIGIT_ZERO) && !link;

  // next state and event side effects
  always_comb begin
    mode_next      = mode;
    go             = 1'b0;
    nines_run_next = nines_run;
    zeros_run_next = zeros_run;
    dig_ctrl       = '0;
    pulse          = 1'b0;
    restart        = 1'b0;
    test           = 1'b0;
    clr            = 1'b0;
    call_x         = CALL_NONE;
    unique case (mode)
      MODE_IDLE: begin
        if (op == OP_HOOK_OFF) begin
          nines_run_next = '0;
          zeros_run_next = '0;
          mode_next      = MODE_TONE;
          go             = 1'b1;
        end else if (op == OP_INCOMING) begin
          mode_next = MODE_RINGING;
          go        = 1'b1;
        end else if (op == OP_DIGIT) begin
          if (digit == DIGIT_NINE) begin
            zeros_run_next = '0;
            if (nines_hit) begin
              nines_run_next = '0;
              test           = 1'b1;
            end else begin
              nines_run_next = nines_run + 2'd1;
            end
          end else if (digit == DIGIT_ZERO) begin
            nines_run_next = '0;
            if (zeros_hit) begin
              zeros_run_next = '0;
              clr            = 1'b1;
              pulse          = 1'b1;
            end else begin
              zeros_run_next = zeros_run + 2'd1;
            end
          end else begin
            nines_run_next = '0;
            zeros_run_next = '0;
          end
        end
      end
      MODE_TONE: begin
        if (op == OP_HOOK_ON) begin
          mode_next = MODE_IDLE;
          go        = 1'b1;
        end else if (op == OP_INCOMING) begin
          mode_next = MODE_RINGING;
          go        = 1'b1;
        end else if ((op == OP_DIGIT) && link) begin
          dig_ctrl.take = 1'b1;
          mode_next     = MODE_DIALING;
          go            = 1'b1;
        end
      end
      MODE_DIALING: begin
        if (op == OP_HOOK_ON) begin
          mode_next = MODE_IDLE;
          go        = 1'b1;
        end else if (op == OP_DIGIT) begin
          dig_ctrl.take = 1'b1;
          if (three_zeros) begin
            clr       = 1'b1;
            pulse     = 1'b1;
            mode_next = MODE_IDLE;
            go        = 1'b1;
          end else begin
            restart = 1'b1;
          end
        end else if (op == OP_TIMEOUT) begin
          mode_next = MODE_OUTGOING;
          go        = 1'b1;
        end
      end
      MODE_OUTGOING: begin
        if (op == OP_HOOK_ON) begin
          call_x    = CALL_HANGUP;
          mode_next = MODE_IDLE;
          go        = 1'b1;
        end else if (op == OP_ANSWERED) begin
          mode_next = MODE_INCALL;
          go        = 1'b1;
        end else if (op == OP_CALL_END) begin
          mode_next = MODE_TONE;
          go        = 1'b1;
        end
      end
      MODE_RINGING: begin
        if (op == OP_HOOK_OFF) begin
          call_x    = CALL_ANSWER;
          mode_next = MODE_INCALL;
          go        = 1'b1;
        end else if (op == OP_ANSWERED) begin
          mode_next = MODE_INCALL;
          go        = 1'b1;
        end else if (op == OP_CALL_END) begin
          mode_next = MODE_IDLE;
          go        = 1'b1;
        end
      end
      MODE_INCALL: begin
        if (op == OP_HOOK_ON) begin
          call_x    = CALL_HANGUP;
          mode_next = MODE_IDLE;
          go        = 1'b1;
        end else if (op == OP_CALL_END) begin
          mode_next = MODE_IDLE;
          go        = 1'b1;
        end
      end
      default: begin
        mode_next = mode;
      end
    endcase
    // entering dial tone empties the digit store
    if (go && (mode_next == MODE_TONE)) begin
      dig_ctrl.clear = 1'b1;
    end
  end

  // commands for the event
  always_comb begin
    cmd.mode  = mode_next;
    cmd.clr   = clr;
    cmd.test  = test;
    cmd.tone  = TONE_NONE;
    cmd.bell  = pulse ? BELL_PULSE : BELL_NONE;
    cmd.call  = call_x;
    cmd.timer = restart ? TIMER_RESTART : TIMER_NONE;
    if (go) begin
      if (mode == MODE_DIALING) begin
        cmd.timer = TIMER_STOP;
      end
      unique case (mode_next)
        MODE_IDLE: begin
          cmd.tone = TONE_STOP;
          if (!pulse) begin
            cmd.bell = BELL_HALT;
          end
        end
        MODE_TONE:     cmd.tone = link ? TONE_DIAL : TONE_BUSY;
        MODE_DIALING:  cmd.tone = TONE_STOP;
        MODE_OUTGOING: cmd.call = CALL_PLACE;
        MODE_RINGING:  cmd.bell = BELL_RING;
        MODE_INCALL:   cmd.bell = BELL_HALT;
        default:       cmd.tone = TONE_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      nines_run <= '0;
      zeros_run <= '0;
    end else if (en) begin
      mode      <= mode_next;
      nines_run <= nines_run_next;
      zeros_run <= zeros_run_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/phone_call_control_fsm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// phone_call_control_fsm
// Handset call control: mode tracking, commands and dialed digit collection.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the input channel (in_valid/in_ready) as one word of
//   operation, digit and link_connected. Every event gives exactly one
//   result word on the output channel (out_valid/out_ready): the new mode,
//   one-shot tone, bell, call and timer commands, the two service flags and
//   the dialed digits collected so far.
//   The service_repeat register is written over its own channel
//   (cfg_valid/cfg_ready); cfg_ready is always high. Write it only while no
//   event is in flight.
//   An accepted event sits in the input register, passes the event logic
//   and lands in the result register, raising out_valid, once that register
//   is free. Throughput is one event per cycle while the receiver takes
//   results, set by the single pass of event logic between the two registers.
//   When the receiver stalls, the result register holds its word and the
//   input register holds the next event; in_ready drops only when both are
//   full. Reset empties both registers, returns to idle, empties the digit
//   store, clears the service runs and sets service_repeat to 3.
// ----------------------------------------------------------------------------
module phone_call_control_fsm
  import pcc_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration channel
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          service_repeat,
  // event channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          operation,
  input  wire logic [3:0]          digit,
  input  wire logic                link_connected,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               new_mode,
  output logic [1:0]               tone_command,
  output logic [1:0]               bell_command,
  output logic [1:0]               call_command,
  output logic [1:0]               timer_command,
  output logic                     clear_pairing,
  output logic                     start_bell_test,
  output logic [COUNT_W-1:0]       dialed_count,
  output logic [NUMBER_W-1:0]      dialed_number
);

  // configuration
  logic [1:0] repeat_cnt;

  // input register
  logic       in_q_valid;
  logic [2:0] op_q;
  logic [3:0] digit_q;
  logic       link_q;

  // pipeline control
  logic in_take;
  logic advance;

  dig_ctrl_t             dig_ctrl;
  dig_stat_t             dig_stat;
  cmd_t                  cmd;
  logic [COUNT_W-1:0]    count_next;
  logic [NUMBER_W-1:0]   number_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_cnt <= SERVICE_REPEAT_RST;
    end else if (cfg_valid) begin
      repeat_cnt <= service_repeat;
    end
  end

  // advance the event into the result register once that slot is free
  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else begin
      in_q_valid <= in_take || (in_q_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_q    <= operation;
      digit_q <= digit;
      link_q  <= link_connected;
    end
  end

  pcc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .op_code    (op_q),
    .digit      (digit_q),
    .link       (link_q),
    .repeat_cnt (repeat_cnt),
    .stat       (dig_stat),
    .dig_ctrl   (dig_ctrl),
    .cmd        (cmd)
  );

  pcc_digits #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_digits (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .ctrl        (dig_ctrl),
    .digit       (digit_q),
    .stat        (dig_stat),
    .count_next  (count_next),
    .number_next (number_next)
  );

  // result register: hold while stalled, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      new_mode        <= cmd.mode;
      tone_command    <= cmd.tone;
      bell_command    <= cmd.bell;
      call_command    <= cmd.call;
      timer_command   <= cmd.timer;
      clear_pairing   <= cmd.clr;
      start_bell_test <= cmd.test;
      dialed_count    <= count_next;
      dialed_number   <= number_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/pcc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks of the phone call control block, bound to the top level.
// ----------------------------------------------------------------------------
module pcc_checker
  import pcc_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [2:0]          new_mode,
  input wire logic [1:0]          bell_command,
  input wire logic                clear_pairing,
  input wire logic                start_bell_test,
  input wire logic [COUNT_W-1:0]  dialed_count,
  input wire logic [NUMBER_W-1:0] dialed_number
);

  // hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_mode)
      && $stable(dialed_count) && $stable(dialed_number))
    else $error("result word changed while stalled");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> dialed_count <= COUNT_W'(MAX_DIGITS))
    else $error("dialed count beyond store size");

  a_tone_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (new_mode == MODE_TONE) |-> (dialed_count == '0)
      && (dialed_number == '0))
    else $error("digits present in dial tone mode");

  a_clear_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid && clear_pairing |-> (bell_command == BELL_PULSE)
      && (new_mode == MODE_IDLE))
    else $error("pairing clear without bell pulse in idle");

  a_test_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_bell_test |-> (new_mode == MODE_IDLE)
      && !clear_pairing)
    else $error("bell test outside idle");

endmodule

bind phone_call_control_fsm pcc_checker #(
  .MAX_DIGITS (MAX_DIGITS)
) u_pcc_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .new_mode        (new_mode),
  .bell_command    (bell_command),
  .clear_pairing   (clear_pairing),
  .start_bell_test (start_bell_test),
  .dialed_count    (dialed_count),
  .dialed_number   (dialed_number)
);
`default_nettype wire
